/* rtl/sorted_set_insert_delete_defines.svh */
// assertion macros for the sorted set block
`ifndef SORTED_SET_INSERT_DELETE_DEFINES_SVH
`define SORTED_SET_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define SSID_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ssid: invariant violated");

// consequent holds in the same cycle as the antecedent
`define SSID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssid: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define SSID_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssid: next-cycle check failed");

`else

`define SSID_ASSERT_ALWAYS(label, cond)
`define SSID_ASSERT_IMP(label, ante, cons)
`define SSID_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/ssid_pkg.sv */
// shared types and constants of the sorted set block
package ssid_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_FULL       = 3'd2,
        ST_DELETED    = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_LIST_ENTRY = 3'd5,
        ST_LIST_EMPTY = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPLY,
        S_LIST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    lookup;
        logic    insert;
        logic    delete;
        logic    rotate;
        logic    emit;
        logic    last;
        status_t code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic found;
        logic full;
        logic empty;
        logic last_entry;
        logic out_free;
    } stat_t;

endpackage

/* rtl/ssid_ifs.sv */
// request and response channel interfaces of the sorted set block
interface ssid_req_if;
    import ssid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ssid_rsp_if;
    import ssid_pkg::*;

    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, output status, output value_res, output last,
                    output count, input ready);
    modport sink   (input valid, input status, input value_res, input last,
                    input count, output ready);
endinterface

/* rtl/ssid_ctrl.sv */
// controller state machine of the sorted set block
module ssid_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_op,
    output logic           req_ready,
    input  ssid_pkg::stat_t stat,
    output ssid_pkg::cmd_t  cmd
);
    import ssid_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.code   = ST_INSERTED;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = req_op;
                    unique case (req_op)
                        OP_INSERT, OP_DELETE: state_next = S_LOOKUP;
                        OP_LIST:              state_next = S_LIST;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            priority if (stat.found)
                            begin
                                cmd.code = ST_DUPLICATE;
                            end
                            else if (stat.full)
                            begin
                                cmd.code = ST_FULL;
                            end
                            else
                            begin
                                cmd.insert = 1'b1;
                                cmd.code   = ST_INSERTED;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (stat.found)
                            begin
                                cmd.delete = 1'b1;
                                cmd.code   = ST_DELETED;
                            end
                            else
                            begin
                                cmd.code = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.empty)
                    begin
                        cmd.code   = ST_LIST_EMPTY;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.code   = ST_LIST_ENTRY;
                        cmd.rotate = 1'b1;
                        cmd.last   = stat.last_entry;
                        if (stat.last_entry)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ssid_dp.sv */
// datapath of the sorted set block: compare-and-shift cells and result register
`include "sorted_set_insert_delete_defines.svh"

module ssid_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [ssid_pkg::DATA_W-1:0] req_value,
    input  ssid_pkg::cmd_t                     cmd,
    output ssid_pkg::stat_t                    stat,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output ssid_pkg::status_t                  rsp_status,
    output logic signed [ssid_pkg::DATA_W-1:0] rsp_value,
    output logic                               rsp_last,
    output logic [ssid_pkg::COUNT_W-1:0]       rsp_count
);
    import ssid_pkg::*;

    logic signed [DATA_W-1:0] cell_reg  [CAPACITY];
    logic signed [DATA_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0]      lt_reg, eq_reg;
    logic [CAPACITY-1:0]      lt_next, eq_next;
    logic signed [DATA_W-1:0] val_reg;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic [OCC_W-1:0]         idx_reg, idx_next;

    logic                     rsp_valid_reg;
    status_t                  rsp_status_reg;
    logic signed [DATA_W-1:0] rsp_value_reg;
    logic                     rsp_last_reg;
    logic [COUNT_W-1:0]       rsp_count_reg;
    logic signed [DATA_W-1:0] out_value;

    // one cell per entry: compare against the request, then shift or rotate
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic valid;
        assign valid      = OCC_W'(g) < occ_reg;
        assign lt_next[g] = valid && (cell_reg[g] < val_reg);
        assign eq_next[g] = valid && (cell_reg[g] == val_reg);

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            priority if (cmd.insert)
            begin
                if (!lt_reg[g])
                begin
                    if (g == 0)
                    begin
                        cell_next[g] = val_reg;
                    end
                    else if (lt_reg[(g == 0) ? 0 : g - 1])
                    begin
                        cell_next[g] = val_reg;
                    end
                    else
                    begin
                        cell_next[g] = cell_reg[(g == 0) ? 0 : g - 1];
                    end
                end
            end
            else if (cmd.delete)
            begin
                if (!lt_reg[g] && (g < CAPACITY - 1))
                begin
                    cell_next[g] = cell_reg[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
            else if (cmd.rotate)
            begin
                // rotate the occupied part left so the next value reaches cell 0
                if (valid)
                begin
                    if (OCC_W'(g + 1) == occ_reg)
                    begin
                        cell_next[g] = cell_reg[0];
                    end
                    else
                    begin
                        cell_next[g] = cell_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    end
                end
            end
            else
            begin
                cell_next[g] = cell_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[g] <= cell_next[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg <= req_value;
        end
        if (cmd.lookup)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (cmd.emit)
        begin
            rsp_status_reg <= cmd.code;
            rsp_value_reg  <= out_value;
            rsp_last_reg   <= cmd.last;
            rsp_count_reg  <= COUNT_W'(occ_next);
        end
    end

    always_comb
    begin
        priority if (cmd.insert)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (cmd.delete)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
        else
        begin
            occ_next = occ_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.capture)
        begin
            idx_next = '0;
        end
        else if (cmd.rotate)
        begin
            idx_next = idx_reg + OCC_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        unique case (cmd.code)
            ST_LIST_ENTRY: out_value = cell_reg[0];
            ST_LIST_EMPTY: out_value = '0;
            default:       out_value = val_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            idx_reg <= idx_next;
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.found      = |eq_reg;
    assign stat.full       = (occ_reg == OCC_W'(CAPACITY));
    assign stat.empty      = (occ_reg == '0);
    assign stat.last_entry = (OCC_W'(idx_reg + OCC_W'(1)) == occ_reg);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_value  = rsp_value_reg;
    assign rsp_last   = rsp_last_reg;
    assign rsp_count  = rsp_count_reg;

    `SSID_ASSERT_ALWAYS(a_occ_bound, occ_reg <= OCC_W'(CAPACITY))
    `SSID_ASSERT_IMP(a_ins_legal, cmd.insert, !stat.found && !stat.full)
    `SSID_ASSERT_NXT(a_ins_grows, cmd.insert, occ_reg == $past(occ_reg) + OCC_W'(1))
    `SSID_ASSERT_NXT(a_del_shrinks, cmd.delete, occ_reg == $past(occ_reg) - OCC_W'(1))
    `SSID_ASSERT_IMP(a_rot_nonempty, cmd.rotate, !stat.empty && cmd.emit)

endmodule

/* rtl/sorted_set_insert_delete.sv */
// top level of the sorted set block: controller, cell datapath and channel ports
//
// keeps up to CAPACITY distinct signed 32-bit values in ascending order in a
// row of compare-and-shift cells. an insert or delete is accepted in S_IDLE,
// compared against every cell in parallel in S_LOOKUP and applied with its
// single status word in S_APPLY once the response side is free; the next
// word is taken right after. a list request is accepted in S_IDLE and then
// gives one response word per stored value (one empty marker if none), read
// at the single read point at cell 0 while the occupied cells rotate left and
// come back to their original order. unused operation code 3 is accepted and
// dropped with no response. a finished response sits in an output register,
// so the next request is taken while it waits; work stalls only when a new
// response word must be written and the old one is still held

module sorted_set_insert_delete (
    input  logic       clk,
    input  logic       rst_n,
    ssid_req_if.sink   req,
    ssid_rsp_if.source rsp
);
    import ssid_pkg::*;

    cmd_t  cmd;   // controller commands to the cells
    stat_t stat;  // compare flags and occupancy back to the controller

    // state machine: sequencing, status code choice, response pacing
    ssid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.operation),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // cells, occupancy, list index and the response register
    ssid_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_value  (req.value),
        .cmd        (cmd),
        .stat       (stat),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_value  (rsp.value_res),
        .rsp_last   (rsp.last),
        .rsp_count  (rsp.count)
    );

endmodule

/* bench/sorted_set_insert_delete_tb.sv */
// self-checking testbench of the sorted set block: directed table, then random traffic
`timescale 1ns / 100ps

module sorted_set_insert_delete_tb;
    import ssid_pkg::*;

    // unused operation code, accepted and dropped by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int ITEM_TARGET = 280;
    localparam int MAX_CYCLES  = 1_000_000;
    localparam int DIR_ROWS    = 25;

    // one response word as the block should send it
    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
        logic [COUNT_W-1:0]       count;
    } reply_t;

    // a directed request; typed rows carry their single response word
    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] val;
        logic                     typed;
        status_t                  st;
        logic signed [DATA_W-1:0] res;
        logic [COUNT_W-1:0]       cnt;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ssid_req_if req_ch ();
    ssid_rsp_if rsp_ch ();

    sorted_set_insert_delete u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // shadow copy of the set, ascending, plus the words still owed by the block
    logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
    int                       shadow_n;
    reply_t                   replies_due [$];

    int bad_words;
    int sent_items;
    bit steady;      // when set, neither side inserts idle cycles

    // directed table: empty store, extremes, duplicates, misses, unused code
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{OP_LIST,   32'sd77,  1'b1, ST_LIST_EMPTY, 32'sd0,  6'd0},
        '{OP_DELETE, 32'sd5,   1'b1, ST_NOT_FOUND,  32'sd5,  6'd0},
        '{OP_INSERT, VAL_MIN,  1'b1, ST_INSERTED,   VAL_MIN, 6'd1},
        '{OP_INSERT, VAL_MAX,  1'b1, ST_INSERTED,   VAL_MAX, 6'd2},
        '{OP_INSERT, 32'sd0,   1'b1, ST_INSERTED,   32'sd0,  6'd3},
        '{OP_INSERT, -32'sd1,  1'b1, ST_INSERTED,   -32'sd1, 6'd4},
        '{OP_INSERT, 32'sd1,   1'b1, ST_INSERTED,   32'sd1,  6'd5},
        '{OP_INSERT, VAL_MIN,  1'b1, ST_DUPLICATE,  VAL_MIN, 6'd5},
        '{OP_INSERT, VAL_MAX,  1'b1, ST_DUPLICATE,  VAL_MAX, 6'd5},
        '{OP_INSERT, 32'sd0,   1'b1, ST_DUPLICATE,  32'sd0,  6'd5},
        '{OP_LIST,   32'sd0,   1'b0, ST_LIST_ENTRY, 32'sd0,  6'd0},
        '{OP_UNUSED, 32'sh5a5a_5a5a, 1'b0, ST_LIST_ENTRY, 32'sd0, 6'd0},
        '{OP_DELETE, 32'sd0,   1'b1, ST_DELETED,    32'sd0,  6'd4},
        '{OP_DELETE, 32'sd0,   1'b1, ST_NOT_FOUND,  32'sd0,  6'd4},
        '{OP_DELETE, VAL_MIN,  1'b1, ST_DELETED,    VAL_MIN, 6'd3},
        '{OP_DELETE, VAL_MAX,  1'b1, ST_DELETED,    VAL_MAX, 6'd2},
        '{OP_DELETE, 32'sd2,   1'b1, ST_NOT_FOUND,  32'sd2,  6'd2},
        '{OP_LIST,   -32'sd9,  1'b0, ST_LIST_ENTRY, 32'sd0,  6'd0},
        '{OP_UNUSED, -32'sd1,  1'b0, ST_LIST_ENTRY, 32'sd0,  6'd0},
        '{OP_DELETE, -32'sd1,  1'b1, ST_DELETED,    -32'sd1, 6'd1},
        '{OP_DELETE, 32'sd1,   1'b1, ST_DELETED,    32'sd1,  6'd0},
        '{OP_LIST,   32'sd12345, 1'b1, ST_LIST_EMPTY, 32'sd0, 6'd0},
        '{OP_INSERT, 32'sh5555_5555, 1'b0, ST_LIST_ENTRY, 32'sd0, 6'd0},
        '{OP_INSERT, 32'shaaaa_aaaa, 1'b0, ST_LIST_ENTRY, 32'sd0, 6'd0},
        '{OP_LIST,   32'sd0,   1'b0, ST_LIST_ENTRY, 32'sd0,  6'd0}
    };

    // ------------------------------------------------------------------
    // shadow set
    // ------------------------------------------------------------------

    // first held position whose value is not below v
    function automatic int find_slot(input logic signed [DATA_W-1:0] v);
        int i;
        i = 0;
        while (i < shadow_n && shadow_vals[i] < v)
            i++;
        return i;
    endfunction

    // count field carries the set size after the operation
    function automatic void owe_word(input status_t st, input logic signed [DATA_W-1:0] v,
                                     input logic last);
        int n;
        n = shadow_n;
        replies_due.push_back(reply_t'{st, v, last, n[COUNT_W-1:0]});
    endfunction

    // update the shadow set for one accepted request and queue its words
    function automatic void apply_to_shadow_set(input logic [1:0] op,
                                                input logic signed [DATA_W-1:0] v);
        int pos;
        int j;
        pos = find_slot(v);
        case (op)
            OP_INSERT:
            begin
                // a value already held wins over a full store
                if (pos < shadow_n && shadow_vals[pos] == v)
                    owe_word(ST_DUPLICATE, v, 1'b1);
                else if (shadow_n >= CAPACITY)
                    owe_word(ST_FULL, v, 1'b1);
                else
                begin
                    for (j = shadow_n; j > pos; j--)
                        shadow_vals[j] = shadow_vals[j-1];
                    shadow_vals[pos] = v;
                    shadow_n++;
                    owe_word(ST_INSERTED, v, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (pos < shadow_n && shadow_vals[pos] == v)
                begin
                    for (j = pos; j + 1 < shadow_n; j++)
                        shadow_vals[j] = shadow_vals[j+1];
                    shadow_n--;
                    owe_word(ST_DELETED, v, 1'b1);
                end
                else
                    owe_word(ST_NOT_FOUND, v, 1'b1);
            end
            OP_LIST:
            begin
                if (shadow_n == 0)
                    owe_word(ST_LIST_EMPTY, '0, 1'b1);
                else
                    for (j = 0; j < shadow_n; j++)
                        owe_word(ST_LIST_ENTRY, shadow_vals[j], j == shadow_n - 1);
            end
            default:
            begin
                // unused code: dropped, nothing owed
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // values: small cluster for collisions, extremes, held values, full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $signed($urandom_range(0, 16)) - 8;
        if (r == 4)
        begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                3: return VAL_MAX - 1;
                4: return 0;
                default: return -1;
            endcase
        end
        if (r < 7 && shadow_n > 0)
            return shadow_vals[$urandom_range(0, shadow_n - 1)];
        return $signed($urandom);
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // present one word at a falling edge, hold it until taken, then predict
    task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            // idle: valid low with junk on the payload
            @(negedge clk);
            req_ch.valid     <= 1'b0;
            req_ch.operation <= 2'($urandom);
            req_ch.value     <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_to_shadow_set(op, v);
        if (op != OP_UNUSED)
            sent_items++;
    endtask

    // ------------------------------------------------------------------
    // clock, reset and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_set_insert_delete_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // response side: random back-pressure and checking
    // ------------------------------------------------------------------

    initial
    begin : ready_driver
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    end

    // every taken word is matched against the oldest owed word
    always @(posedge clk)
    begin : response_check
        reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("unexpected word: status %0d value_res %0d last %0b count %0d",
                       rsp_ch.status, rsp_ch.value_res, rsp_ch.last, rsp_ch.count);
                bad_words++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    bad_words++;
                end
                if (rsp_ch.value_res !== want.value_res)
                begin
                    $error("value_res: expected %0d, got %0d", want.value_res,
                           rsp_ch.value_res);
                    bad_words++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                    bad_words++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    bad_words++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int r;
        logic signed [DATA_W-1:0] v;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        shadow_n         = 0;
        bad_words        = 0;
        sent_items       = 0;
        steady           = 1'b0;

        // single reset, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; typed rows replace the predicted word with the literal one
        for (int k = 0; k < DIR_ROWS; k++)
        begin
            send_word(directed_rows[k].op, directed_rows[k].val);
            if (directed_rows[k].typed)
                replies_due[replies_due.size() - 1] =
                    '{directed_rows[k].st, directed_rows[k].res, 1'b1,
                      directed_rows[k].cnt};
        end

        // fill the store to capacity, some collisions along the way
        while (shadow_n < CAPACITY)
            send_word(OP_INSERT, ($urandom_range(0, 3) == 0) ? pick_value() : $signed($urandom));

        // full store: duplicate beats full, then a fresh value is refused
        send_word(OP_INSERT, shadow_vals[$urandom_range(0, CAPACITY - 1)]);
        do
            v = $signed($urandom);
        while (find_slot(v) < shadow_n && shadow_vals[find_slot(v)] == v);
        send_word(OP_INSERT, v);
        send_word(OP_LIST, $signed($urandom));
        send_word(OP_UNUSED, $signed($urandom));
        send_word(OP_DELETE, shadow_vals[$urandom_range(0, CAPACITY - 1)]);
        send_word(OP_INSERT, v);
        send_word(OP_INSERT, VAL_MIN);

        // mixed traffic; the idle style of both sides is redrawn at every multiple of 20 items sent
        while (sent_items < ITEM_TARGET - 24)
        begin
            if (sent_items % 20 == 0)
                steady = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 42)
                send_word(OP_INSERT, pick_value());
            else if (r < 80)
                send_word(OP_DELETE, (shadow_n > 0 && $urandom_range(0, 4) < 3) ?
                          shadow_vals[$urandom_range(0, shadow_n - 1)] : pick_value());
            else if (r < 94)
                send_word(OP_LIST, $signed($urandom));
            else
                send_word(OP_UNUSED, $signed($urandom));
        end

        // drain the store in random order, then confirm it lists empty
        steady = 1'b0;
        while (shadow_n > 0)
            send_word(OP_DELETE, shadow_vals[$urandom_range(0, shadow_n - 1)]);
        send_word(OP_LIST, $signed($urandom));

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // wait for every owed word, then a margin for strays
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (bad_words == 0)
            $display("sorted_set_insert_delete_tb: PASS");
        else
            $display("sorted_set_insert_delete_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssid_pkg.sv
rtl/ssid_ifs.sv
rtl/ssid_ctrl.sv
rtl/ssid_dp.sv
rtl/sorted_set_insert_delete.sv
bench/sorted_set_insert_delete_tb.sv
